// ----- rtl/ecta_pkg.sv -----
package ecta_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int BLK_W       = 9;

  localparam logic [POS_W-1:0] LAST_POS      = POS_W'(BLOCK_BYTES - 1);
  localparam logic [POS_W-1:0] EXT_COUNT_POS = POS_W'(126);
  localparam logic [POS_W-1:0] DTD_POS       = POS_W'(2);
  localparam logic [POS_W-1:0] DBC_START     = POS_W'(4);
  localparam logic [BLK_W-1:0] BLK_MAX       = {BLK_W{1'b1}};

  localparam logic [7:0] CTA_EXT_TAG    = 8'h02;
  localparam logic [2:0] TAG_EXTENDED   = 3'h7;
  localparam logic [7:0] TARGET_DEFAULT = 8'h06;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic hdr_found;
    logic too_short;
  } result_t;

  // input register toward the parser
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// ----- rtl/ecta_if.sv -----
interface ecta_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, data_byte, last, input ready);
  modport sink (input valid, data_byte, last, output ready);
endinterface

interface ecta_result_if;
  logic valid;
  logic ready;
  logic hdr_found;
  logic too_short;
  modport source (output valid, hdr_found, too_short, input ready);
  modport sink (input valid, hdr_found, too_short, output ready);
endinterface

interface ecta_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/ecta_in_reg.sv -----
module ecta_in_reg (
  input  logic               clk,
  input  logic               rst,
  ecta_byte_if.sink          edid,
  input  logic               advance,
  output ecta_pkg::stage_t   stage
);

  ecta_pkg::stage_t stage_next;
  logic             take;

  assign edid.ready = !stage.valid || advance;
  assign take       = edid.valid && edid.ready;

  always_comb begin
    stage_next = stage;
    if (take) begin
      stage_next.valid          = 1'b1;
      stage_next.item.data_byte = edid.data_byte;
      stage_next.item.last      = edid.last;
    end else if (advance) begin
      stage_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
    stage.item <= stage_next.item;
  end

endmodule

// ----- rtl/ecta_parser.sv -----
module ecta_parser (
  input  logic                clk,
  input  logic                rst,
  input  ecta_pkg::stage_t    stage,
  input  logic                advance,
  input  logic [7:0]          target_ext_tag,
  output logic                push,
  output ecta_pkg::result_t   result
);

  logic [ecta_pkg::POS_W-1:0] byte_in_block, byte_in_block_next;
  logic [ecta_pkg::BLK_W-1:0] block_number, block_number_next;
  logic [7:0]                 extension_count, extension_count_next;
  logic                       block_is_cta, block_is_cta_next;
  logic [7:0]                 dtd_offset, dtd_offset_next;
  logic [7:0]                 next_header_pos, next_header_pos_next;
  logic                       ext_tag_pending, ext_tag_pending_next;
  logic                       hit_in_block, hit_in_block_next;
  logic                       found, found_next;

  logic [7:0]                 b;
  logic [ecta_pkg::POS_W-1:0] pos;
  logic [7:0]                 pos8;
  logic                       counted;

  assign b    = stage.item.data_byte;
  assign pos  = byte_in_block;
  assign pos8 = 8'(pos);

  always_comb begin
    block_is_cta_next    = block_is_cta;
    dtd_offset_next      = dtd_offset;
    next_header_pos_next = next_header_pos;
    ext_tag_pending_next = ext_tag_pending;
    hit_in_block_next    = hit_in_block;
    extension_count_next = extension_count;
    block_number_next    = block_number;
    found_next           = found;
    byte_in_block_next   = pos + ecta_pkg::POS_W'(1);

    if (pos == '0) begin
      block_is_cta_next    = (b == ecta_pkg::CTA_EXT_TAG);
      dtd_offset_next      = 8'd0;
      next_header_pos_next = 8'(ecta_pkg::DBC_START);
      ext_tag_pending_next = 1'b0;
      hit_in_block_next    = 1'b0;
    end
    if (block_number == '0 && pos == ecta_pkg::EXT_COUNT_POS) begin
      extension_count_next = b;
    end
    if (pos == ecta_pkg::DTD_POS) begin
      dtd_offset_next = b;
    end

    if (ext_tag_pending_next) begin
      if (b == target_ext_tag) begin
        hit_in_block_next = 1'b1;
      end
      ext_tag_pending_next = 1'b0;
    end

    // header walk over the data block collection
    if (block_is_cta_next && pos >= ecta_pkg::DBC_START && pos8 == next_header_pos_next
        && pos8 < dtd_offset_next) begin
      if (b[7:5] == ecta_pkg::TAG_EXTENDED) begin
        ext_tag_pending_next = 1'b1;
      end
      next_header_pos_next = pos8 + 8'(b[4:0]) + 8'd1;
    end

    counted = hit_in_block_next && block_number != '0
              && block_number <= {1'b0, extension_count_next};
    if (pos == ecta_pkg::LAST_POS) begin
      if (counted) begin
        found_next = 1'b1;
      end
      if (block_number != ecta_pkg::BLK_MAX) begin
        block_number_next = block_number + ecta_pkg::BLK_W'(1);
      end
      byte_in_block_next   = '0;
      ext_tag_pending_next = 1'b0;
    end
  end

  assign push             = advance && stage.item.last;
  assign result.hdr_found = found_next;
  assign result.too_short = (block_number_next == '0);

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_in_block   <= '0;
      block_number    <= '0;
      extension_count <= 8'd0;
      block_is_cta    <= 1'b0;
      dtd_offset      <= 8'd0;
      next_header_pos <= 8'(ecta_pkg::DBC_START);
      ext_tag_pending <= 1'b0;
      hit_in_block    <= 1'b0;
      found           <= 1'b0;
    end else if (advance) begin
      byte_in_block   <= byte_in_block_next;
      block_number    <= block_number_next;
      extension_count <= extension_count_next;
      block_is_cta    <= block_is_cta_next;
      dtd_offset      <= dtd_offset_next;
      next_header_pos <= next_header_pos_next;
      ext_tag_pending <= ext_tag_pending_next;
      hit_in_block    <= hit_in_block_next;
      found           <= found_next;
    end
  end

endmodule

// ----- rtl/ecta_out_reg.sv -----
module ecta_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ecta_pkg::result_t  result_in,
  output logic               can_take,
  ecta_result_if.source      result
);

  logic              valid;
  ecta_pkg::result_t held;

  assign can_take         = !valid || result.ready;
  assign result.valid     = valid;
  assign result.hdr_found = held.hdr_found;
  assign result.too_short = held.too_short;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
    if (push) begin
      held <= result_in;
    end
  end

endmodule

// ----- rtl/edid_cta_hdr_block_detector.sv -----
// channel  dir  payload                    accepted when
// edid     in   data_byte[7:0], last       edid.valid && edid.ready
// result   out  hdr_found, too_short       result.valid && result.ready
// cfg      in   data[7:0] (target_ext_tag) cfg.valid && cfg.ready
//
// One byte per cycle unless a last byte is held: input register, then the byte
// parser, which updates its counters and compares; the result is registered.
// rst is synchronous; target_ext_tag resets to 6, parser state to its idle values.
// A last byte waits in the input register only while the result register is full
// and not being taken, and edid is held off meanwhile; otherwise a byte is taken
// every cycle. cfg is always ready.
module edid_cta_hdr_block_detector (
  input  logic          clk,
  input  logic          rst,
  ecta_byte_if.sink     edid,
  ecta_result_if.source result,
  ecta_cfg_if.sink      cfg
);

  ecta_pkg::stage_t  stage;
  ecta_pkg::result_t parsed;
  logic              advance;
  logic              push;
  logic              can_take;
  logic [7:0]        target_ext_tag;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_ext_tag <= ecta_pkg::TARGET_DEFAULT;
    end else if (cfg.valid) begin
      target_ext_tag <= cfg.data;
    end
  end

  // a last byte moves on only if the result slot frees up
  assign advance = stage.valid && (!stage.item.last || can_take);

  ecta_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .edid    (edid),
    .advance (advance),
    .stage   (stage)
  );

  ecta_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .stage          (stage),
    .advance        (advance),
    .target_ext_tag (target_ext_tag),
    .push           (push),
    .result         (parsed)
  );

  ecta_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .result_in (parsed),
    .can_take  (can_take),
    .result    (result)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {IMG_WELL_FORMED, IMG_NOISE, IMG_SHORT} img_kind_t;

  logic clk = 1'b0;
  logic rst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ecta_byte_if   edid_bus ();
  ecta_result_if result_bus ();
  ecta_cfg_if    cfg_bus ();

  edid_cta_hdr_block_detector u_top (
    .clk    (clk),
    .rst    (rst),
    .edid   (edid_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // scanner copy: register and per-image parse state
  logic [7:0] target_tag;
  logic [6:0] scan_pos;
  logic [8:0] scan_blk;
  logic [7:0] ext_count;
  bit         blk_is_cta;
  logic [7:0] dtd_off;
  logic [7:0] next_hdr_pos;
  bit         ext_pending;
  bit         blk_hit;
  bit         img_found;

  ecta_pkg::result_t expected_verdicts[$];
  ecta_pkg::result_t want;
  logic [7:0]        image_q[$];
  logic [7:0]        blk_buf[128];

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int hold_len = 0;
  int hold_cnt = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_phase = 0;

  function automatic void clear_scan();
    scan_pos     = '0;
    scan_blk     = '0;
    ext_count    = '0;
    blk_is_cta   = 1'b0;
    dtd_off      = '0;
    next_hdr_pos = 8'(ecta_pkg::DBC_START);
    ext_pending  = 1'b0;
    blk_hit      = 1'b0;
    img_found    = 1'b0;
  endfunction

  // one byte through the scanner; returns 1 when the byte closes an image
  function automatic bit scan_edid_byte(input logic [7:0] b, input bit is_last,
                                        output ecta_pkg::result_t verdict);
    logic [6:0] p;
    p = scan_pos;
    verdict = '0;
    if (p == 7'd0) begin
      blk_is_cta   = (b == ecta_pkg::CTA_EXT_TAG);
      dtd_off      = '0;
      next_hdr_pos = 8'(ecta_pkg::DBC_START);
      ext_pending  = 1'b0;
      blk_hit      = 1'b0;
    end
    if (scan_blk == '0 && p == ecta_pkg::EXT_COUNT_POS)
      ext_count = b;
    if (p == ecta_pkg::DTD_POS)
      dtd_off = b;
    if (ext_pending) begin
      if (b == target_tag)
        blk_hit = 1'b1;
      ext_pending = 1'b0;
    end
    if (blk_is_cta && p >= ecta_pkg::DBC_START && {1'b0, p} == next_hdr_pos
        && {1'b0, p} < dtd_off) begin
      if (b[7:5] == ecta_pkg::TAG_EXTENDED)
        ext_pending = 1'b1;
      next_hdr_pos = {1'b0, p} + {3'b000, b[4:0]} + 8'd1;
    end
    if (p == ecta_pkg::LAST_POS) begin
      if (blk_hit && scan_blk >= 9'd1 && scan_blk <= {1'b0, ext_count})
        img_found = 1'b1;
      if (scan_blk != ecta_pkg::BLK_MAX)
        scan_blk = scan_blk + 9'd1;
      scan_pos    = '0;
      ext_pending = 1'b0;
    end else begin
      scan_pos = p + 7'd1;
    end
    if (is_last) begin
      verdict.hdr_found = img_found;
      verdict.too_short = (scan_blk == '0);
      clear_scan();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    rx_phase = (rx_phase + 1) % 5;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      result_bus.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: result_bus.ready <= 1'b1;
        1: result_bus.ready <= ($urandom_range(0, 99) >= 40);
        default: result_bus.ready <= (rx_phase != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no image pending: hdr_found %0b too_short %0b",
               result_bus.hdr_found, result_bus.too_short);
        fail_cnt++;
      end else begin
        want = expected_verdicts.pop_front();
        if (result_bus.hdr_found !== want.hdr_found) begin
          $error("hdr_found: expected %0b, actual %0b", want.hdr_found, result_bus.hdr_found);
          fail_cnt++;
        end
        if (result_bus.too_short !== want.too_short) begin
          $error("too_short: expected %0b, actual %0b", want.too_short, result_bus.too_short);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[edid_cta_hdr_block_detector] ERROR");
      $finish;
    end
  end

  // ---------------- driving helpers ----------------
  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit is_last);
    int gap;
    ecta_pkg::result_t verdict;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        edid_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    edid_bus.valid     <= 1'b1;
    edid_bus.data_byte <= b;
    edid_bus.last      <= is_last;
    do @(posedge clk); while (!edid_bus.ready);
    if (scan_edid_byte(b, is_last, verdict))
      expected_verdicts.push_back(verdict);
    @(negedge clk);
  endtask

  task automatic send_image();
    for (int i = 0; i < image_q.size(); i++)
      send_byte(image_q[i], i == image_q.size() - 1);
    image_q.delete();
  endtask

  task automatic settle_block();
    edid_bus.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_target(input logic [7:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    target_tag = v;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // zero fill walks as one-byte tag-0 headers and never hits
  task automatic new_block(input logic [7:0] b0, input logic [7:0] dtd, input bit rand_fill);
    for (int i = 0; i < 128; i++)
      blk_buf[i] = rand_fill ? 8'($urandom) : 8'h00;
    blk_buf[0] = b0;
    blk_buf[2] = dtd;
  endtask

  task automatic push_block(input int n);
    for (int i = 0; i < n; i++)
      image_q.push_back(blk_buf[i]);
  endtask

  task automatic add_hit(input int p, input int len);
    blk_buf[p] = {ecta_pkg::TAG_EXTENDED, 5'(len)};
    blk_buf[p + 1] = target_tag;
  endtask

  task automatic push_base_block(input logic [7:0] cnt);
    new_block(8'h00, 8'h00, 1'b0);
    blk_buf[126] = cnt;
    push_block(128);
  endtask

  task automatic push_hit_block(input logic [7:0] dtd, input int p);
    new_block(ecta_pkg::CTA_EXT_TAG, dtd, 1'b0);
    add_hit(p, 1);
    push_block(128);
  endtask

  task automatic gen_block(input bit first, input logic [7:0] cnt, input bit cta, input int hit_pct);
    int p;
    int len;
    int r;
    logic [7:0] dtd;
    r = $urandom_range(0, 9);
    if (r == 0)
      dtd = 8'($urandom_range(0, 4));
    else if (r == 1)
      dtd = 8'($urandom_range(128, 255));
    else
      dtd = 8'($urandom_range(5, 127));
    new_block(cta ? ecta_pkg::CTA_EXT_TAG : 8'($urandom), dtd, 1'b1);
    p = int'(ecta_pkg::DBC_START);
    while (p < dtd && p < 128) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
      if ($urandom_range(0, 99) < hit_pct) begin
        blk_buf[p] = {ecta_pkg::TAG_EXTENDED, 5'(len)};
        if (p < 127)
          blk_buf[p + 1] = ($urandom_range(0, 3) != 0) ? target_tag : 8'($urandom);
      end else begin
        blk_buf[p] = {3'($urandom_range(0, 6)), 5'(len)};
      end
      p += len + 1;
    end
    if (first)
      blk_buf[126] = cnt;
    push_block(128);
  endtask

  task automatic gen_random_image();
    img_kind_t kind;
    int r;
    int nblk;
    int n;
    logic [7:0] cnt;
    r = $urandom_range(0, 9);
    kind = (r < 7) ? IMG_WELL_FORMED : (r < 9) ? IMG_NOISE : IMG_SHORT;
    case (kind)
      IMG_WELL_FORMED: begin
        nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
        r = $urandom_range(0, 5);
        if (r == 0)
          cnt = 8'($urandom);
        else if (r == 1)
          cnt = 8'($urandom_range(0, nblk + 1));
        else
          cnt = 8'(nblk - 1);
        gen_block(1'b1, cnt, $urandom_range(0, 9) == 0, 20);
        for (int i = 1; i < nblk; i++)
          gen_block(1'b0, cnt, $urandom_range(0, 9) != 0, $urandom_range(0, 40));
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(1, 127);
          repeat (n) void'(image_q.pop_back());
        end
      end
      IMG_NOISE: begin
        n = $urandom_range(1, 300);
        repeat (n) image_q.push_back(8'($urandom));
      end
      default: begin
        n = $urandom_range(1, 130);
        repeat (n) image_q.push_back(8'($urandom));
      end
    endcase
  endtask

  // ---------------- tests ----------------
  task automatic test_default_target();
    push_base_block(8'd1);
    push_hit_block(8'd40, 4);
    send_image();
    settle_block();
  endtask

  task automatic test_short_images();
    image_q.push_back(8'h00);
    send_image();
    image_q.push_back(8'hFF);
    send_image();
    repeat (127) image_q.push_back(8'h5A);
    send_image();
    repeat (128) image_q.push_back(8'hFF);
    send_image();
    repeat (129) image_q.push_back(8'hA5);
    send_image();
    settle_block();
  endtask

  task automatic test_walk_limits();
    push_base_block(8'd3);
    // long header runs past the block end; the later hit is unreachable
    new_block(ecta_pkg::CTA_EXT_TAG, 8'd255, 1'b0);
    blk_buf[100] = {3'd1, 5'd31};
    add_hit(120, 1);
    push_block(128);
    // extended header on the final byte; its tag byte sits in the next block
    new_block(ecta_pkg::CTA_EXT_TAG, 8'd255, 1'b0);
    blk_buf[127] = {ecta_pkg::TAG_EXTENDED, 5'd0};
    push_block(128);
    new_block(target_tag, 8'h00, 1'b0);
    push_block(128);
    send_image();
    settle_block();
  endtask

  task automatic test_dtd_offsets();
    logic [7:0] offsets[5] = '{8'd0, 8'd4, 8'd5, 8'd127, 8'd128};
    foreach (offsets[i]) begin
      push_base_block(8'd1);
      push_hit_block(offsets[i], 4);
      send_image();
    end
    settle_block();
  endtask

  task automatic test_zero_length();
    push_base_block(8'd1);
    new_block(ecta_pkg::CTA_EXT_TAG, 8'd60, 1'b0);
    add_hit(10, 0);
    push_block(128);
    send_image();
    push_base_block(8'd1);
    new_block(ecta_pkg::CTA_EXT_TAG, 8'd60, 1'b0);
    blk_buf[10] = {ecta_pkg::TAG_EXTENDED, 5'd0};
    blk_buf[11] = {ecta_pkg::TAG_EXTENDED, 5'd0};
    blk_buf[12] = target_tag;
    push_block(128);
    send_image();
    settle_block();
  endtask

  task automatic test_partial_block();
    push_base_block(8'd1);
    new_block(ecta_pkg::CTA_EXT_TAG, 8'd40, 1'b0);
    add_hit(4, 1);
    push_block(100);
    send_image();
    push_base_block(8'd2);
    push_hit_block(8'd40, 4);
    push_hit_block(8'd40, 8);
    void'(image_q.pop_back());
    send_image();
    settle_block();
  endtask

  task automatic test_block_count();
    logic [7:0] counts[5] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255};
    foreach (counts[i]) begin
      push_base_block(counts[i]);
      new_block(ecta_pkg::CTA_EXT_TAG, 8'd40, 1'b0);
      push_block(128);
      push_hit_block(8'd40, 6);
      new_block(ecta_pkg::CTA_EXT_TAG, 8'd40, 1'b0);
      push_block(128);
      send_image();
    end
    settle_block();
  endtask

  task automatic test_target_values();
    logic [7:0] values[4];
    values = '{8'h00, 8'hFF, 8'($urandom), ecta_pkg::TARGET_DEFAULT};
    foreach (values[i]) begin
      write_target(values[i]);
      push_base_block(8'd2);
      push_hit_block(8'd127, 4);
      new_block(ecta_pkg::CTA_EXT_TAG, 8'd127, 1'b0);
      blk_buf[4] = {ecta_pkg::TAG_EXTENDED, 5'd1};
      blk_buf[5] = ~target_tag;
      push_block(128);
      send_image();
      settle_block();
    end
  endtask

  // result side holds off; last bytes back up into the input register
  task automatic test_output_stall();
    hold_len = 400;
    for (int i = 0; i < 30; i++) begin
      image_q.push_back(8'($urandom));
      send_image();
    end
    push_base_block(8'd1);
    push_hit_block(8'd30, 4);
    send_image();
    settle_block();
  endtask

  task automatic test_random_images();
    int bytes_sent;
    int images;
    logic [7:0] v;
    bytes_sent = 0;
    images = 0;
    while (bytes_sent < 2000) begin
      if (images % 8 == 7) begin
        settle_block();
        case ($urandom_range(0, 3))
          0: v = 8'h00;
          1: v = 8'hFF;
          2: v = 8'($urandom);
          default: v = ecta_pkg::TARGET_DEFAULT;
        endcase
        write_target(v);
      end
      gen_random_image();
      bytes_sent += image_q.size();
      images++;
      send_image();
    end
    settle_block();
  endtask

  initial begin
    rst = 1'b1;
    edid_bus.valid = 1'b0;
    edid_bus.data_byte = 8'h00;
    edid_bus.last = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = 8'h00;
    result_bus.ready = 1'b0;
    target_tag = ecta_pkg::TARGET_DEFAULT;
    clear_scan();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_target();
    test_short_images();
    test_walk_limits();
    test_dtd_offsets();
    test_zero_length();
    test_partial_block();
    test_block_count();
    test_target_values();
    test_output_stall();
    test_random_images();

    settle_block();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && expected_verdicts.size() == 0)
      $display("[edid_cta_hdr_block_detector] OK");
    else
      $display("[edid_cta_hdr_block_detector] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ecta_pkg.sv
rtl/ecta_if.sv
rtl/ecta_in_reg.sv
rtl/ecta_parser.sv
rtl/ecta_out_reg.sv
rtl/edid_cta_hdr_block_detector.sv
tb/tb_top.sv
